[rtl/core/ucs_pkg.sv]
`default_nettype none
package ucs_pkg;

  localparam int FRAC_BITS = 16;
  localparam int MAX_KNOTS = 1024;
  localparam int KNOT_AW   = 10;
  localparam int BANK_AW   = KNOT_AW - 1;
  localparam int BANK_DEPTH = MAX_KNOTS / 2;
  localparam int WORD_W    = 32;
  localparam int CNT_W     = 11;
  localparam int CFG_AW    = 3;

  typedef logic signed [63:0] wide_t;
  typedef logic signed [WORD_W-1:0] word_t;

  // configuration register indexes
  typedef enum logic [CFG_AW-1:0] {
    REG_X_START     = 3'd0,
    REG_INV_STEP    = 3'd1,
    REG_KNOT_COUNT  = 3'd2,
    REG_EXTRAPOLATE = 3'd3,
    REG_MONOTONIC   = 3'd4
  } cfg_reg_t;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  localparam wide_t ONE      = wide_t'(64'sd1 <<< FRAC_BITS);
  localparam logic [63:0] CLIP_LIM = 64'd1 << 62;

endpackage
`default_nettype wire

[rtl/core/ucs_ram.sv]
`default_nettype none
module ucs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr0,
  input  wire logic [$clog2(DEPTH)-1:0] raddr1,
  output logic      [WIDTH-1:0]         rdata0,
  output logic      [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule
`default_nettype wire

[rtl/core/ucs_qmul.sv]
`default_nettype none
module ucs_qmul
  import ucs_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  en,
  input  wire wide_t a,
  input  wire wide_t b,
  output wide_t      y
);

  // floor(a*b / 2^F) clipped to +-2^62; four 32x32 partials are registered, then summed and registered as y
  logic [63:0] ua, ub;
  logic [63:0] p0, p1, p2, p3;
  logic        neg;
  logic [33:0] mid;
  logic [63:0] lo, hi, qlo, qhi, qr;
  logic        clip;

  assign ua = a[63] ? (64'd0 - a) : a;
  assign ub = b[63] ? (64'd0 - b) : b;

  always_ff @(posedge clk) begin
    if (en) begin
      p0  <= ua[31:0]  * ub[31:0];
      p1  <= ua[31:0]  * ub[63:32];
      p2  <= ua[63:32] * ub[31:0];
      p3  <= ua[63:32] * ub[63:32];
      neg <= a[63] != b[63];
    end
  end

  always_comb begin
    mid  = 34'(p0[63:32]) + 34'(p1[31:0]) + 34'(p2[31:0]);
    lo   = {mid[31:0], p0[31:0]};
    hi   = p3 + 64'(p1[63:32]) + 64'(p2[63:32]) + 64'(mid[33:32]);
    qlo  = {hi[FRAC_BITS-1:0], lo[63:FRAC_BITS]};
    qhi  = hi >> FRAC_BITS;
    clip = (qhi != 64'd0) || (qlo >= CLIP_LIM);
    qr   = qlo + 64'((neg && (p0[FRAC_BITS-1:0] != '0)) ? 1 : 0);
    if (clip) begin
      qr = CLIP_LIM;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y <= neg ? wide_t'(64'd0 - qr) : wide_t'(qr);
    end
  end

endmodule
`default_nettype wire

[rtl/core/uniform_cubic_spline_eval.sv]
`default_nettype none
// Uniform-grid cubic spline evaluator. Knots live in two 512-word RAM banks
// split by index parity, so the four neighbors of any bin come out of the two
// read ports of each bank together. A write item (tuser = 0) stores a
// knot; an evaluate item (tuser = 1) returns value, slope and a saturation
// flag. One item is taken per cycle while the output is not stalled. Knot
// writes update the RAM at the same stage that evaluations read it, so items
// always see the knots in acceptance order. The pipeline advances as a whole
// and stalls only while the output register holds a result that has not
// been taken. Configuration is taken at any time but must only change while
// the block is idle.
module uniform_cubic_spline_eval
  import ucs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CFG_AW-1:0] cfg_index,
  input  wire logic [31:0]       cfg_data,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [79:0]       s_tdata,  // knot_index[9:0], knot_value[41:10], x_coord[73:42]
  input  wire logic [0:0]        s_tuser,  // op
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic      [63:0]       m_tdata,  // value[31:0], slope[63:32]
  output logic      [0:0]        m_tuser   // saturated
);

  typedef struct packed {
    wide_t t;
    wide_t p1;
    wide_t p2;
    wide_t m1;
    wide_t cb;
    wide_t cb2;
    wide_t extv;
    wide_t exts;
    logic  past;
  } side_t;

  // configuration
  word_t            x_start;
  logic [31:0]      inv_step;
  logic [CNT_W-1:0] knot_count;
  logic             extrapolate;
  logic             monotonic;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_start     <= '0;
      inv_step    <= 32'(ONE);
      knot_count  <= CNT_W'(2);
      extrapolate <= 1'b0;
      monotonic   <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_X_START:     x_start     <= cfg_data;
        REG_INV_STEP:    inv_step    <= cfg_data;
        REG_KNOT_COUNT:  knot_count  <= cfg_data[CNT_W-1:0];
        REG_EXTRAPOLATE: extrapolate <= cfg_data[0];
        REG_MONOTONIC:   monotonic   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // advance the whole pipeline unless the output register is blocked
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  logic [15:1] v;

  // stage 1: offset from first knot
  logic              op1;
  logic [KNOT_AW-1:0] idx1;
  word_t             kval1;
  logic signed [32:0] d1;

  // stage 2: position product
  logic              op2;
  logic [KNOT_AW-1:0] idx2;
  word_t             kval2;
  logic [63:0]       mag2;
  logic              dneg2;

  always_ff @(posedge clk) begin
    if (en) begin
      op1   <= s_tuser[0];
      idx1  <= s_tdata[9:0];
      kval1 <= s_tdata[41:10];
      d1    <= 33'(signed'(s_tdata[73:42])) - 33'(x_start);
      op2   <= op1;
      idx2  <= idx1;
      kval2 <= kval1;
      mag2  <= (d1[32] ? 32'(-d1) : 32'(d1)) * inv_step;
      dneg2 <= d1[32];
    end
  end

  // stage 2: bin, fraction, RAM access
  logic [CNT_W-1:0]   n_eff;
  logic [KNOT_AW-1:0] imax, ib, am1, a1, a2;
  wide_t              t2;
  logic [64:0]        up2;
  logic [BANK_AW-1:0] e_r0, e_r1, o_r0, o_r1;
  logic               we_e, we_o;

  always_comb begin
    n_eff = knot_count;
    if (n_eff < CNT_W'(2)) n_eff = CNT_W'(2);
    if (n_eff > CNT_W'(MAX_KNOTS)) n_eff = CNT_W'(MAX_KNOTS);
    imax = KNOT_AW'(n_eff - CNT_W'(2));
    if (dneg2) begin
      ib  = '0;
      up2 = 65'(mag2) + 65'((64'd1 << FRAC_BITS) - 64'd1);
      t2  = wide_t'(64'd0 - up2[64:FRAC_BITS]);
    end else begin
      ib  = (mag2[63:2*FRAC_BITS] > (64-2*FRAC_BITS)'(imax)) ? imax :
            mag2[2*FRAC_BITS+KNOT_AW-1:2*FRAC_BITS];
      up2 = '0;
      t2  = wide_t'(mag2 >> FRAC_BITS) - (wide_t'(ib) <<< FRAC_BITS);
    end
    am1 = ib - KNOT_AW'(1);
    a1  = ib + KNOT_AW'(1);
    a2  = ib + KNOT_AW'(2);
    if (!ib[0]) begin
      e_r0 = ib[KNOT_AW-1:1];
      e_r1 = a2[KNOT_AW-1:1];
      o_r0 = am1[KNOT_AW-1:1];
      o_r1 = a1[KNOT_AW-1:1];
    end else begin
      e_r0 = am1[KNOT_AW-1:1];
      e_r1 = a1[KNOT_AW-1:1];
      o_r0 = ib[KNOT_AW-1:1];
      o_r1 = a2[KNOT_AW-1:1];
    end
    we_e = en && v[2] && (op2 == OP_WRITE) && !idx2[0];
    we_o = en && v[2] && (op2 == OP_WRITE) && idx2[0];
  end

  logic [WORD_W-1:0] e_d0, e_d1, o_d0, o_d1;

  ucs_ram #(.WIDTH(WORD_W), .DEPTH(BANK_DEPTH)) u_even (
    .clk(clk), .we(we_e), .waddr(idx2[KNOT_AW-1:1]), .wdata(kval2),
    .re(en), .raddr0(e_r0), .raddr1(e_r1), .rdata0(e_d0), .rdata1(e_d1)
  );

  ucs_ram #(.WIDTH(WORD_W), .DEPTH(BANK_DEPTH)) u_odd (
    .clk(clk), .we(we_o), .waddr(idx2[KNOT_AW-1:1]), .wdata(kval2),
    .re(en), .raddr0(o_r0), .raddr1(o_r1), .rdata0(o_d0), .rdata1(o_d1)
  );

  // stage 3: knot words arrive
  logic  first3, last3, odd3, past3;
  wide_t t3;

  always_ff @(posedge clk) begin
    if (en) begin
      first3 <= ib == '0;
      last3  <= ib == imax;
      odd3   <= ib[0];
      t3     <= t2;
      past3  <= !dneg2 && (t2 >= ONE);
    end
  end

  // stage 4: mirrored neighbors
  wide_t p0_4, p1_4, p2_4, p3_4, t4;
  logic  past4;
  wide_t q0, q1, q2, q3;

  always_comb begin
    if (!odd3) begin
      q1 = wide_t'(signed'(e_d0));
      q3 = wide_t'(signed'(e_d1));
      q0 = wide_t'(signed'(o_d0));
      q2 = wide_t'(signed'(o_d1));
    end else begin
      q0 = wide_t'(signed'(e_d0));
      q2 = wide_t'(signed'(e_d1));
      q1 = wide_t'(signed'(o_d0));
      q3 = wide_t'(signed'(o_d1));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_4  <= q1;
      p2_4  <= q2;
      p0_4  <= first3 ? ((q1 <<< 1) - q2) : q0;
      p3_4  <= last3 ? ((q2 <<< 1) - q1) : q3;
      t4    <= t3;
      past4 <= past3;
    end
  end

  // stage 5: differences and raw tangents
  wide_t dl5, dm5, dr5, m1_5, m2_5, p1_5, p2_5, t5;
  logic  past5;

  always_ff @(posedge clk) begin
    if (en) begin
      dl5   <= p1_4 - p0_4;
      dm5   <= p2_4 - p1_4;
      dr5   <= p3_4 - p2_4;
      m1_5  <= (p2_4 - p0_4) >>> 1;
      m2_5  <= (p3_4 - p1_4) >>> 1;
      p1_5  <= p1_4;
      p2_5  <= p2_4;
      t5    <= t4;
      past5 <= past4;
    end
  end

  // zero a tangent across an extremum or a flat side, else cap it at three times the smaller slope
  function automatic wide_t limit_tangent(wide_t m, wide_t dl, wide_t dr);
    wide_t r;
    logic  same;
    r    = m;
    same = ((dl > 0) && (dr > 0)) || ((dl < 0) && (dr < 0));
    if (!same) r = '0;
    if (r > 0) begin
      if (r > 3 * ((dr < dl) ? dr : dl)) r = 3 * ((dr < dl) ? dr : dl);
    end else if (r < 0) begin
      if (r < 3 * ((dr > dl) ? dr : dl)) r = 3 * ((dr > dl) ? dr : dl);
    end
    return r;
  endfunction

  // stage 6: tangents final
  wide_t m1_6, m2_6, p1_6, p2_6, t6;
  logic  past6;

  always_ff @(posedge clk) begin
    if (en) begin
      m1_6  <= monotonic ? limit_tangent(m1_5, dl5, dm5) : m1_5;
      m2_6  <= monotonic ? limit_tangent(m2_5, dm5, dr5) : m2_5;
      p1_6  <= p1_5;
      p2_6  <= p2_5;
      t6    <= t5;
      past6 <= past5;
    end
  end

  // stage 7: cubic coefficients, operands of the first products
  wide_t ca6, cb6;
  wide_t a1a, a1b, b1a, b1b;
  side_t sd7, sd8, sd9;

  assign ca6 = (p1_6 <<< 1) + m1_6 - (p2_6 <<< 1) + m2_6;
  assign cb6 = 3 * (p2_6 - p1_6) - (m1_6 <<< 1) - m2_6;

  always_ff @(posedge clk) begin
    if (en) begin
      // past the end, reuse the first products for the linear extension
      a1a <= past6 ? (t6 - ONE) : ca6;
      a1b <= past6 ? m2_6 : t6;
      b1a <= past6 ? m2_6 : 3 * ca6;
      b1b <= past6 ? wide_t'({32'd0, inv_step}) : t6;
      sd7 <= '{t: t6, p1: p1_6, p2: p2_6, m1: m1_6, cb: cb6, cb2: cb6 <<< 1,
               extv: '0, exts: '0, past: past6};
    end
  end

  wide_t a1y, b1y, a2y, b2y, a3y, b3y;

  ucs_qmul u_a1 (.clk(clk), .en(en), .a(a1a), .b(a1b), .y(a1y));
  ucs_qmul u_b1 (.clk(clk), .en(en), .a(b1a), .b(b1b), .y(b1y));

  // stage 10: first Horner step
  wide_t h10, s10, h13, s13;
  side_t sd9x;
  side_t sd10, sd11, sd12, sd13, sd14, sd15;

  always_comb begin
    sd9x      = sd9;
    sd9x.extv = sd9.p2 + a1y;
    sd9x.exts = b1y;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd8  <= sd7;
      sd9  <= sd8;
      h10  <= a1y + sd9.cb;
      s10  <= b1y + sd9.cb2;
      sd10 <= sd9x;
    end
  end

  ucs_qmul u_a2 (.clk(clk), .en(en), .a(h10), .b(sd10.t), .y(a2y));
  ucs_qmul u_b2 (.clk(clk), .en(en), .a(s10), .b(sd10.t), .y(b2y));

  // stage 13: second Horner step
  always_ff @(posedge clk) begin
    if (en) begin
      sd11 <= sd10;
      sd12 <= sd11;
      h13  <= a2y + sd12.m1;
      s13  <= b2y + sd12.m1;
      sd13 <= sd12;
    end
  end

  ucs_qmul u_a3 (.clk(clk), .en(en), .a(h13), .b(sd13.t), .y(a3y));
  ucs_qmul u_b3 (.clk(clk), .en(en), .a(s13), .b(wide_t'({32'd0, inv_step})), .y(b3y));

  always_ff @(posedge clk) begin
    if (en) begin
      sd14 <= sd13;
      sd15 <= sd14;
    end
  end

  // stage 15: select result and clip to 32 bits
  wide_t val15, slp15;
  word_t val_sat, slp_sat;
  logic  clip15;

  always_comb begin
    if (sd15.past) begin
      val15 = extrapolate ? sd15.extv : sd15.p2;
      slp15 = extrapolate ? sd15.exts : '0;
    end else begin
      val15 = a3y + sd15.p1;
      slp15 = b3y;
    end
    clip15 = 1'b0;
    if (val15 > wide_t'(32'sh7fffffff)) begin
      val_sat = 32'sh7fffffff;
      clip15  = 1'b1;
    end else if (val15 < -wide_t'(64'sh80000000)) begin
      val_sat = 32'sh80000000;
      clip15  = 1'b1;
    end else begin
      val_sat = val15[31:0];
    end
    if (slp15 > wide_t'(32'sh7fffffff)) begin
      slp_sat = 32'sh7fffffff;
      clip15  = 1'b1;
    end else if (slp15 < -wide_t'(64'sh80000000)) begin
      slp_sat = 32'sh80000000;
      clip15  = 1'b1;
    end else begin
      slp_sat = slp15[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata    <= {slp_sat, val_sat};
      m_tuser[0] <= clip15;
    end
  end

  // valid chain; write items leave once they reach the RAM
  always_ff @(posedge clk) begin
    if (rst) begin
      v        <= '0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      v[1]     <= s_tvalid;
      v[2]     <= v[1];
      v[3]     <= v[2] && (op2 == OP_EVAL);
      v[15:4]  <= v[14:3];
      m_tvalid <= v[15];
    end
  end

endmodule
`default_nettype wire

[test/uniform_cubic_spline_eval_checker.sv]
`timescale 1ns / 1ps
module uniform_cubic_spline_eval_checker
  import ucs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  input  wire logic              cfg_ready,
  input  wire logic [CFG_AW-1:0] cfg_index,
  input  wire logic [31:0]       cfg_data,
  input  wire logic              s_tvalid,
  input  wire logic              s_tready,
  input  wire logic [79:0]       s_tdata,
  input  wire logic [0:0]        s_tuser,
  input  wire logic              m_tvalid,
  input  wire logic              m_tready,
  input  wire logic [63:0]       m_tdata,
  input  wire logic [0:0]        m_tuser,
  output int                     errors,
  output int                     pending
);

  typedef struct packed {
    logic signed [31:0] value;
    logic signed [31:0] slope;
    logic               sat;
  } spline_out_t;

  localparam longint CLIP = longint'(CLIP_LIM);

  logic signed [31:0] knots [0:MAX_KNOTS-1];
  longint             origin;
  logic [31:0]        inv_step;
  logic [CNT_W-1:0]   knot_count;
  logic               extrap_on;
  logic               mono_on;
  spline_out_t        expected_q [$];

  // floor(a*b / 2^F), clipped to +-2^62
  function automatic longint fx_mul(longint a, longint b);
    logic signed [127:0] pa, pb, prod;
    pa = a;
    pb = b;
    prod = (pa * pb) >>> FRAC_BITS;
    if (prod > CLIP) return CLIP;
    if (prod < -CLIP) return -CLIP;
    return longint'(prod);
  endfunction

  function automatic longint clamp_tangent(longint m, longint dl, longint dr);
    longint lo, hi;
    lo = (dl < dr) ? dl : dr;
    hi = (dl > dr) ? dl : dr;
    if ((dl > 0 && dr <= 0) || (dl < 0 && dr >= 0) || dl == 0) m = 0;
    if (m > 0) m = (m < 3 * lo) ? m : 3 * lo;
    else if (m < 0) m = (m > 3 * hi) ? m : 3 * hi;
    return m;
  endfunction

  function automatic longint clip32(longint v, ref logic sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic spline_out_t eval_spline(logic signed [31:0] x);
    longint      one, n, imax, d, ib, t, p0, p1, p2, p3, m1, m2, ca, cb, h, s, val, slp;
    logic [63:0] mag;
    logic        sat;
    spline_out_t r;
    one = ONE;
    n = knot_count;
    if (n < 2) n = 2;
    if (n > MAX_KNOTS) n = MAX_KNOTS;
    imax = n - 2;
    d = longint'(x) - origin;
    mag = (d < 0 ? -d : d) * longint'({32'd0, inv_step});
    if (d >= 0) begin
      ib = ((mag >> (2 * FRAC_BITS)) > imax) ? imax : longint'(mag >> (2 * FRAC_BITS));
      t = longint'(mag >> FRAC_BITS) - ib * one;
    end else begin
      ib = 0;
      t = -longint'((mag + 64'(one - 1)) >> FRAC_BITS);
    end
    p1 = knots[ib];
    p2 = knots[ib + 1];
    p0 = (ib == 0) ? 2 * p1 - p2 : longint'(knots[ib - 1]);
    p3 = (ib == imax) ? 2 * p2 - p1 : longint'(knots[ib + 2]);
    m1 = (p2 - p0) >>> 1;
    m2 = (p3 - p1) >>> 1;
    if (mono_on) begin
      m1 = clamp_tangent(m1, p1 - p0, p2 - p1);
      m2 = clamp_tangent(m2, p2 - p1, p3 - p2);
    end
    if (t >= one) begin
      // beyond the last knot: extend linearly or hold the end value
      val = extrap_on ? p2 + fx_mul(t - one, m2) : p2;
      slp = extrap_on ? fx_mul(m2, longint'({32'd0, inv_step})) : 0;
    end else begin
      ca = 2 * p1 + m1 - 2 * p2 + m2;
      cb = -3 * p1 + 3 * p2 - 2 * m1 - m2;
      h = fx_mul(ca, t) + cb;
      h = fx_mul(h, t) + m1;
      val = fx_mul(h, t) + p1;
      s = fx_mul(3 * ca, t) + 2 * cb;
      s = fx_mul(s, t) + m1;
      slp = fx_mul(s, longint'({32'd0, inv_step}));
    end
    sat = 1'b0;
    r.value = 32'(clip32(val, sat));
    r.slope = 32'(clip32(slp, sat));
    r.sat = sat;
    return r;
  endfunction

  always @(posedge clk) begin
    spline_out_t exp_r;
    if (rst) begin
      errors = 0;
      origin = 0;
      inv_step = 32'd1 << FRAC_BITS;
      knot_count = 2;
      extrap_on = 1'b0;
      mono_on = 1'b0;
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_X_START:     origin = longint'($signed(cfg_data));
          REG_INV_STEP:    inv_step = cfg_data;
          REG_KNOT_COUNT:  knot_count = cfg_data[CNT_W-1:0];
          REG_EXTRAPOLATE: extrap_on = cfg_data[0];
          REG_MONOTONIC:   mono_on = cfg_data[0];
          default: ;
        endcase
      end
      // compare the result first: it was computed from earlier items only
      if (m_tvalid && m_tready) begin
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result value=%h slope=%h sat=%b", $time,
                   m_tdata[31:0], m_tdata[63:32], m_tuser[0]);
        end else begin
          exp_r = expected_q.pop_front();
          if (m_tdata[31:0] !== exp_r.value) begin
            errors++;
            $display("%0t: value expected %h actual %h", $time, exp_r.value, m_tdata[31:0]);
          end
          if (m_tdata[63:32] !== exp_r.slope) begin
            errors++;
            $display("%0t: slope expected %h actual %h", $time, exp_r.slope, m_tdata[63:32]);
          end
          if (m_tuser[0] !== exp_r.sat) begin
            errors++;
            $display("%0t: saturated expected %b actual %b", $time, exp_r.sat, m_tuser[0]);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser[0] == OP_WRITE) knots[s_tdata[9:0]] = s_tdata[41:10];
        else expected_q.push_back(eval_spline(s_tdata[73:42]));
      end
    end
    pending = expected_q.size();
  end

endmodule

[test/uniform_cubic_spline_eval_tb.sv]
`timescale 1ns / 1ps
module uniform_cubic_spline_eval_tb;
  import ucs_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 24;  // a little over the pipeline depth

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_AW-1:0] cfg_index = '0;
  logic [31:0]       cfg_data = '0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [79:0]       s_tdata = '0;  // knot_index[9:0], knot_value[41:10], x_coord[73:42]
  logic [0:0]        s_tuser = '0;  // op
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [63:0]       m_tdata;       // value[31:0], slope[63:32]
  logic [0:0]        m_tuser;       // saturated
  int                errors;
  int                pending;

  // local copy of the settings, used to shape the stimulus
  logic signed [31:0] cur_origin;
  logic [31:0]        cur_inv;
  int                 cur_knots;
  bit                 loaded [0:MAX_KNOTS-1];
  int                 burst_left = 0;
  int                 idle_cycles = 0;
  bit                 hold_req = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  uniform_cubic_spline_eval u_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  uniform_cubic_spline_eval_checker u_check (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .errors(errors), .pending(pending)
  );

  // Receiver: alternate between free-flowing and randomly stalling stretches,
  // and once hold off for a long stretch so the pipeline backs up.
  always @(posedge clk) begin
    int mode_left, stall_pct, hold_left;
    bit held;
    if (rst) begin
      m_tready <= 1'b0;
      mode_left = 0;
      hold_left = 0;
      held = 0;
    end else begin
      if (!held && hold_req) begin
        hold_left = 400;
        held = 1;
      end
      if (mode_left == 0) begin
        mode_left = $urandom_range(10, 80);
        stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 80);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(1, 100) > stall_pct);
      end
    end
  end

  // Watchdog: any handshake resets the idle count.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("uniform_cubic_spline_eval_tb: errors");
      $finish;
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [31:0] data);
    bit ok;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do begin
      @(negedge clk);
      ok = cfg_ready;
      @(posedge clk);
    end while (!ok);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_X_START:    cur_origin = data;
      REG_INV_STEP:   cur_inv = data;
      REG_KNOT_COUNT: cur_knots = (data[CNT_W-1:0] < 2) ? 2 :
                                  (data[CNT_W-1:0] > MAX_KNOTS) ? MAX_KNOTS : int'(data[CNT_W-1:0]);
      default: ;
    endcase
  endtask

  // Offer one item and hold it until taken; insert a random gap between bursts.
  task automatic send_item(logic op, logic [9:0] idx, logic [31:0] kval, logic [31:0] x);
    bit ok;
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {6'd0, x, kval, idx};
    do begin
      @(negedge clk);
      ok = s_tready;
      @(posedge clk);
    end while (!ok);
    if (op == OP_WRITE) loaded[idx] = 1;
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_knot();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom();
      default: return 32'($urandom_range(0, 32'h7ffff)) - 32'h40000;
    endcase
  endfunction

  // Mostly land on or near the knot span; sometimes anywhere.
  function automatic logic [31:0] pick_x();
    longint span, off;
    if (cur_inv == 0 || $urandom_range(0, 4) == 0) return $urandom();
    span = ((longint'(cur_knots) + 1) <<< 32) / longint'({32'd0, cur_inv});
    off = longint'({32'd0, $urandom()}) % (span + span / 2 + 1) - span / 4;
    return 32'(longint'(cur_origin) + off);
  endfunction

  initial begin
    logic [31:0] xs, inv, cnt;
    for (int k = 0; k < MAX_KNOTS; k++) loaded[k] = 0;
    cur_origin = 0;
    cur_inv = 32'd1 << FRAC_BITS;
    cur_knots = 2;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes on the reset settings (two knots, unit step)
    send_item(OP_WRITE, 10'd0, 32'h7fffffff, 32'h0);
    send_item(OP_WRITE, 10'd1, 32'h80000000, 32'hffffffff);
    send_item(OP_WRITE, 10'd1023, 32'h0, 32'h0);
    send_item(OP_EVAL, 10'h3ff, 32'hffffffff, 32'h80000000);  // far below first knot
    send_item(OP_EVAL, 10'd0, 32'd0, 32'h7fffffff);           // far past last knot
    send_item(OP_EVAL, 10'd0, 32'd0, 32'h00000000);
    send_item(OP_EVAL, 10'd0, 32'd0, 32'h00008000);
    send_item(OP_EVAL, 10'd0, 32'd0, 32'h00010000);           // exactly on last knot
    send_item(OP_EVAL, 10'd0, 32'd0, 32'h00018000);
    send_item(OP_WRITE, 10'd1, 32'h00010000, 32'd0);
    send_item(OP_EVAL, 10'd0, 32'd0, 32'hffff8000);
    wait_idle();

    for (int phase = 0; phase < 13; phase++) begin
      case (phase)
        0: begin xs = 32'h80000000; inv = 32'hffffffff; cnt = 32'd1024; end
        1: begin xs = 32'h7fffffff; inv = 32'd1;        cnt = 32'd2047; end
        2: begin xs = $urandom();   inv = 32'd0;        cnt = 32'd0;    end  // zero step
        3: begin xs = 32'd0;        inv = 32'h10000;    cnt = 32'd1;    end
        default: begin
          xs = ($urandom_range(0, 1) == 0) ? $urandom() : 32'($urandom_range(0, 32'h3ffff)) - 32'h20000;
          inv = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(32'h1000, 32'h100000);
          cnt = ($urandom_range(0, 5) == 0) ? $urandom() : $urandom_range(3, 16);
        end
      endcase
      write_reg(REG_X_START, xs);
      write_reg(REG_INV_STEP, inv);
      write_reg(REG_KNOT_COUNT, cnt);
      write_reg(REG_EXTRAPOLATE, {31'($urandom()), phase[0]});
      write_reg(REG_MONOTONIC, {31'($urandom()), phase[1] ^ phase[2]});

      // load every knot in use that was never written
      for (int k = 0; k < cur_knots; k++)
        if (!loaded[k])
          send_item(OP_WRITE, 10'(k), pick_knot(), $urandom());

      // one phase sends evaluations only while the receiver holds off
      if (phase == 4) hold_req = 1'b1;
      repeat (24) begin
        if (phase != 4 && $urandom_range(0, 3) == 0)
          send_item(OP_WRITE, 10'($urandom_range(0, MAX_KNOTS - 1)), pick_knot(), $urandom());
        else
          send_item(OP_EVAL, 10'($urandom()), $urandom(), pick_x());
      end
      wait_idle();
    end

    if (errors == 0) begin
      $display("uniform_cubic_spline_eval_tb: clean");
    end else begin
      $display("uniform_cubic_spline_eval_tb: errors");
    end
    $finish;
  end

endmodule
